### rtl/pevp_pkg.sv
// ----------------------------------------------------------------------------
// pevp_pkg
// shared types, command codes and register constants of the victim picker
// ----------------------------------------------------------------------------
package pevp_pkg;

   // build-time defaults
   localparam int PAGE_CAPACITY_DEF = 65536;
   localparam int RING_CAPACITY_DEF = 1024 * 16;
   localparam int WORD_BITS_DEF     = 64;

   // fixed field widths
   localparam int CMD_W      = 3;
   localparam int PAGE_W     = 16;
   localparam int PCOUNT_W   = 17;
   localparam int RLOG_W     = 4;
   localparam int RETRY_W    = 8;
   localparam int RIDX_W     = 14;
   localparam int RING_LOG2_MAX = 14;
   localparam int CSR_IDX_W  = 2;

   // register reset values
   localparam logic [PCOUNT_W-1:0] PAGE_COUNT_RESET = 17'd65536;
   localparam logic [RLOG_W-1:0]   RING_LOG2_RESET  = 4'd14;
   localparam logic [RETRY_W-1:0]  RETRY_RESET      = 8'd123;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_LOG2  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY      = 2'd2;

   // command codes
   localparam logic [CMD_W-1:0] OP_INIT    = 3'd0;
   localparam logic [CMD_W-1:0] OP_CHOOSE  = 3'd1;
   localparam logic [CMD_W-1:0] OP_OUT     = 3'd2;
   localparam logic [CMD_W-1:0] OP_IN      = 3'd3;
   localparam logic [CMD_W-1:0] OP_IN_NR   = 3'd4;
   localparam logic [CMD_W-1:0] OP_DROP    = 3'd5;
   localparam logic [CMD_W-1:0] OP_NOP     = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]  op;
      logic [PAGE_W-1:0] page;
   } cmd_type;

   typedef struct packed {
      logic [PAGE_W-1:0] victim_page;
      logic              found;
      logic              must_wait;
      logic              tried_cleared;
   } rsp_type;

   typedef struct packed {
      logic [PCOUNT_W-1:0] page_count;
      logic [RLOG_W-1:0]   ring_depth_log2;
      logic [RETRY_W-1:0]  retry_rounds;
   } cfg_type;

endpackage

### rtl/pevp_front.sv
// ----------------------------------------------------------------------------
// pevp_front
// input side: takes commands, classifies them and queues them for the engine
// ----------------------------------------------------------------------------
module pevp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [2:0]             req_command,
   input  logic [15:0]            req_page_number,
   output logic                   cmd_valid,
   output pevp_pkg::cmd_type      cmd,
   input  logic                   cmd_pop
);
   import pevp_pkg::*;

   cmd_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     cls;
   logic        do_push, do_pop;

   // unknown codes become a no-op
   always_comb begin
      cls.page = req_page_number;
      case (req_command)
         OP_INIT, OP_CHOOSE, OP_OUT, OP_IN, OP_IN_NR, OP_DROP: cls.op = req_command;
         default: cls.op = OP_NOP;
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

### rtl/pevp_engine.sv
// ----------------------------------------------------------------------------
// pevp_engine
// back side: page bitmaps, recent ring, scan pointer and command sequencer
// ----------------------------------------------------------------------------
module pevp_engine #(
   parameter int PAGE_CAPACITY = pevp_pkg::PAGE_CAPACITY_DEF,
   parameter int RING_CAPACITY = pevp_pkg::RING_CAPACITY_DEF,
   parameter int WORD_BITS     = pevp_pkg::WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pevp_pkg::cfg_type     cfg,
   input  logic                  cmd_valid,
   input  pevp_pkg::cmd_type     cmd,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output pevp_pkg::rsp_type     rsp_data
);
   import pevp_pkg::*;

   localparam int LANES     = 1 << ($clog2(WORD_BITS + 1) - 1);
   localparam int LW        = $clog2(LANES);
   localparam int MAP_WORDS = (PAGE_CAPACITY + LANES - 1) / LANES;
   localparam int MW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int RCAP_LOG2 = $clog2(RING_CAPACITY + 1) - 1;
   localparam int RING_LOG2 = (RCAP_LOG2 < RING_LOG2_MAX) ? RCAP_LOG2 : RING_LOG2_MAX;
   localparam int RING_DEPTH = 1 << RING_LOG2;
   localparam int RW        = (RING_LOG2 > 0) ? RING_LOG2 : 1;
   localparam int NW        = $clog2(PAGE_CAPACITY + 1);
   localparam int SWEEP_LEN = (MAP_WORDS > RING_DEPTH) ? MAP_WORDS : RING_DEPTH;
   localparam int SW        = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_CLEAR    = 3'd1;
   localparam logic [2:0] S_SETUP    = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_PIN_RD   = 3'd4;
   localparam logic [2:0] S_PIN_WR   = 3'd5;
   localparam logic [2:0] S_RING_RD  = 3'd6;
   localparam logic [2:0] S_RING_USE = 3'd7;

   // memories
   logic [LANES-1:0]  pin_mem  [MAP_WORDS];
   logic [LANES-1:0]  try_mem  [MAP_WORDS];
   logic [PAGE_W:0]   ring_mem [RING_DEPTH];
   logic [LANES-1:0]  pin_rd_ff, try_rd_ff;
   logic [PAGE_W:0]   ring_rd_ff;

   logic              pin_we, try_we, ring_we;
   logic [MW-1:0]     map_wa, map_ra;
   logic [LANES-1:0]  pin_wd, try_wd;
   logic [RW-1:0]     ring_wa, ring_ra;
   logic [PAGE_W:0]   ring_wd;

   // sequencer state
   logic [2:0]         state_ff, state_in;
   logic [SW-1:0]      sweep_ff, sweep_in;
   logic [SW-1:0]      sweep_last_ff, sweep_last_in;
   logic               clr_all_ff, clr_all_in;
   logic               push_done_ff, push_done_in;
   rsp_type            res_ff, res_in;
   logic [NW-1:0]      ptr_ff, ptr_in;
   logic [RETRY_W-1:0] failed_ff, failed_in;
   logic [RIDX_W-1:0]  ring_index_ff, ring_index_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [PAGE_W-1:0]  rmw_page_ff, rmw_page_in;
   logic               pin_val_ff, pin_val_in;
   logic               try_clr_ff, try_clr_in;
   logic               pend_new_ff, pend_new_in;
   logic               keep_ff, keep_in;
   logic [RW-1:0]      slot_ff, slot_in;
   logic [NW-1:0]      start_ff, start_in;
   logic [NW-1:0]      nm1_ff, nm1_in;
   logic               iss_on_ff, iss_on_in;
   logic [MW-1:0]      iss_w_ff, iss_w_in;
   logic               iss_seg_ff, iss_seg_in;
   logic               ev_on_ff, ev_on_in;
   logic [MW-1:0]      ev_w_ff, ev_w_in;
   logic               ev_seg_ff, ev_seg_in;
   logic               ev_last_ff, ev_last_in;

   // helpers
   logic [NW-1:0]      eff_n;
   logic [NW:0]        ptr_inc;
   logic [RIDX_W-1:0]  slot_mask;
   logic [RLOG_W-1:0]  ring_k;
   logic [MW-1:0]      iss_hi_w, ev_lo_w, ev_hi_w;
   logic [NW-1:0]      ev_lo, ev_hi;
   logic [LANES-1:0]   ev_mask, ev_free, ev_bit, rmw_bit;
   logic [LW-1:0]      ev_idx;
   logic               iss_last;
   logic [MW-1:0]      rmw_word;
   logic               rmw_ok;
   logic [RETRY_W:0]   fail_cnt;

   function automatic logic [LW-1:0] low_idx(input logic [LANES-1:0] v);
      logic [LW-1:0] r;
      r = '0;
      for (int j = LANES - 1; j >= 0; j--) begin
         if (v[j]) r = LW'(j);
      end
      return r;
   endfunction

   // effective page count and ring slot
   always_comb begin
      if (cfg.page_count == '0) begin
         eff_n = NW'(1);
      end else if (32'(cfg.page_count) > PAGE_CAPACITY) begin
         eff_n = NW'(PAGE_CAPACITY);
      end else begin
         eff_n = NW'(cfg.page_count);
      end
      ring_k    = (cfg.ring_depth_log2 > RLOG_W'(RING_LOG2)) ? RLOG_W'(RING_LOG2)
                                                             : cfg.ring_depth_log2;
      slot_mask = (RIDX_W'(1) << ring_k) - RIDX_W'(1);
      ptr_inc   = {1'b0, ptr_ff} + (NW+1)'(1);
   end

   // scan window bookkeeping: segment 0 runs start..n-1, segment 1 runs 0..start-1
   always_comb begin
      iss_hi_w = iss_seg_ff ? MW'((start_ff - NW'(1)) >> LW) : MW'(nm1_ff >> LW);
      iss_last = (iss_w_ff == iss_hi_w) && (iss_seg_ff || (start_ff == '0));
      ev_lo    = ev_seg_ff ? '0 : start_ff;
      ev_hi    = ev_seg_ff ? (start_ff - NW'(1)) : nm1_ff;
      ev_lo_w  = MW'(ev_lo >> LW);
      ev_hi_w  = MW'(ev_hi >> LW);
      ev_mask  = '1;
      if (ev_w_ff == ev_lo_w) ev_mask = ev_mask & ({LANES{1'b1}} << ev_lo[LW-1:0]);
      if (ev_w_ff == ev_hi_w) begin
         ev_mask = ev_mask & ({LANES{1'b1}} >> (LW'(LANES - 1) - ev_hi[LW-1:0]));
      end
      ev_free  = ~pin_rd_ff & ~try_rd_ff & ev_mask;
      ev_idx   = low_idx(ev_free);
      ev_bit   = LANES'(1) << ev_idx;
      rmw_word = MW'(rmw_page_ff >> LW);
      rmw_ok   = 32'(rmw_page_ff) < PAGE_CAPACITY;
      rmw_bit  = LANES'(1) << rmw_page_ff[LW-1:0];
      fail_cnt = {1'b0, failed_ff} + (RETRY_W+1)'(1);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      sweep_last_in = sweep_last_ff;
      clr_all_in    = clr_all_ff;
      push_done_in  = push_done_ff;
      res_in        = res_ff;
      ptr_in        = ptr_ff;
      failed_in     = failed_ff;
      ring_index_in = ring_index_ff;
      page_in       = page_ff;
      rmw_page_in   = rmw_page_ff;
      pin_val_in    = pin_val_ff;
      try_clr_in    = try_clr_ff;
      pend_new_in   = pend_new_ff;
      keep_in       = keep_ff;
      slot_in       = slot_ff;
      start_in      = start_ff;
      nm1_in        = nm1_ff;
      iss_on_in     = 1'b0;
      iss_w_in      = iss_w_ff;
      iss_seg_in    = iss_seg_ff;
      ev_on_in      = 1'b0;
      ev_w_in       = iss_w_ff;
      ev_seg_in     = iss_seg_ff;
      ev_last_in    = iss_last;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_data      = '0;
      pin_we  = 1'b0;
      try_we  = 1'b0;
      ring_we = 1'b0;
      map_wa  = rmw_word;
      map_ra  = rmw_word;
      pin_wd  = '0;
      try_wd  = '0;
      ring_wa = slot_ff;
      ring_ra = slot_ff;
      ring_wd = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop     = 1'b1;
               page_in     = cmd.page;
               rmw_page_in = cmd.page;
               pend_new_in = 1'b0;
               keep_in     = (cmd.op == OP_IN);
               slot_in     = RW'(ring_index_ff & slot_mask);
               case (cmd.op)
                  OP_INIT: begin
                     state_in      = S_CLEAR;
                     sweep_in      = '0;
                     sweep_last_in = SW'(SWEEP_LEN - 1);
                     clr_all_in    = 1'b1;
                     push_done_in  = 1'b1;
                     res_in        = '0;
                  end
                  OP_CHOOSE: state_in = S_SETUP;
                  OP_OUT: begin
                     pin_val_in = 1'b1;
                     try_clr_in = 1'b1;
                     state_in   = S_PIN_RD;
                  end
                  OP_IN, OP_IN_NR: state_in = S_RING_RD;
                  OP_DROP: begin
                     pin_val_in = 1'b0;
                     try_clr_in = 1'b0;
                     state_in   = S_PIN_RD;
                  end
                  default: rsp_push = 1'b1;
               endcase
            end
         end

         S_CLEAR: begin
            map_wa  = MW'(sweep_ff);
            ring_wa = RW'(sweep_ff);
            if (32'(sweep_ff) < MAP_WORDS) begin
               try_we = 1'b1;
               pin_we = clr_all_ff;
               pin_wd = (sweep_ff == '0) ? LANES'(1) : '0;
            end
            ring_we = clr_all_ff && (32'(sweep_ff) < RING_DEPTH);
            sweep_in = sweep_ff + SW'(1);
            if (sweep_ff == sweep_last_ff) begin
               state_in = S_IDLE;
               rsp_push = push_done_ff;
               rsp_data = res_ff;
               if (clr_all_ff) begin
                  ptr_in        = eff_n >> 1;
                  ring_index_in = '0;
                  failed_in     = '0;
               end
            end
         end

         S_SETUP: begin
            nm1_in     = eff_n - NW'(1);
            start_in   = (ptr_inc >= {1'b0, eff_n}) ? '0 : ptr_inc[NW-1:0];
            iss_w_in   = (ptr_inc >= {1'b0, eff_n}) ? '0 : MW'(ptr_inc[NW-1:0] >> LW);
            iss_seg_in = 1'b0;
            iss_on_in  = 1'b1;
            state_in   = S_SCAN;
         end

         S_SCAN: begin
            // issue one word per cycle, evaluate it the cycle after
            map_ra    = iss_w_ff;
            ev_on_in  = iss_on_ff;
            iss_on_in = iss_on_ff;
            if (iss_on_ff) begin
               if (iss_w_ff == iss_hi_w) begin
                  if (!iss_seg_ff && (start_ff != '0)) begin
                     iss_seg_in = 1'b1;
                     iss_w_in   = '0;
                  end else begin
                     iss_on_in = 1'b0;
                  end
               end else begin
                  iss_w_in = iss_w_ff + MW'(1);
               end
            end
            if (ev_on_ff) begin
               if (ev_free != '0) begin
                  try_we    = 1'b1;
                  map_wa    = ev_w_ff;
                  try_wd    = try_rd_ff | ev_bit;
                  ptr_in    = NW'({ev_w_ff, ev_idx});
                  rsp_push  = 1'b1;
                  rsp_data.victim_page = PAGE_W'({ev_w_ff, ev_idx});
                  rsp_data.found       = 1'b1;
                  iss_on_in = 1'b0;
                  ev_on_in  = 1'b0;
                  state_in  = S_IDLE;
               end else if (ev_last_ff) begin
                  // failed pass
                  ptr_in    = (ptr_ff <= nm1_ff) ? ptr_ff : nm1_ff;
                  iss_on_in = 1'b0;
                  ev_on_in  = 1'b0;
                  if (fail_cnt > {1'b0, cfg.retry_rounds}) begin
                     failed_in     = '0;
                     state_in      = S_CLEAR;
                     sweep_in      = '0;
                     sweep_last_in = SW'(MAP_WORDS - 1);
                     clr_all_in    = 1'b0;
                     push_done_in  = 1'b1;
                     res_in        = '0;
                     res_in.must_wait     = 1'b1;
                     res_in.tried_cleared = 1'b1;
                  end else begin
                     failed_in          = fail_cnt[RETRY_W-1:0];
                     rsp_push           = 1'b1;
                     rsp_data.must_wait = 1'b1;
                     state_in           = S_IDLE;
                  end
               end
            end
         end

         S_PIN_RD: state_in = S_PIN_WR;

         S_PIN_WR: begin
            pin_we = rmw_ok;
            try_we = rmw_ok && try_clr_ff;
            pin_wd = pin_val_ff ? (pin_rd_ff | rmw_bit) : (pin_rd_ff & ~rmw_bit);
            try_wd = try_rd_ff & ~rmw_bit;
            if (pend_new_ff) begin
               pend_new_in = 1'b0;
               rmw_page_in = page_ff;
               state_in    = S_PIN_RD;
            end else begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_RING_RD: state_in = S_RING_USE;

         S_RING_USE: begin
            ring_we       = 1'b1;
            ring_wd       = keep_ff ? {1'b1, page_ff} : '0;
            ring_index_in = ring_index_ff + RIDX_W'(1);
            pin_val_in    = 1'b0;
            try_clr_in    = 1'b0;
            if (ring_rd_ff[PAGE_W]) begin
               rmw_page_in = ring_rd_ff[PAGE_W-1:0];
               pend_new_in = !keep_ff;
               state_in    = S_PIN_RD;
            end else if (!keep_ff) begin
               rmw_page_in = page_ff;
               state_in    = S_PIN_RD;
            end else begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         sweep_ff      <= '0;
         sweep_last_ff <= SW'(SWEEP_LEN - 1);
         clr_all_ff    <= 1'b1;
         push_done_ff  <= 1'b0;
         failed_ff     <= '0;
         ring_index_ff <= '0;
         iss_on_ff     <= 1'b0;
         ev_on_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         sweep_last_ff <= sweep_last_in;
         clr_all_ff    <= clr_all_in;
         push_done_ff  <= push_done_in;
         failed_ff     <= failed_in;
         ring_index_ff <= ring_index_in;
         iss_on_ff     <= iss_on_in;
         ev_on_ff      <= ev_on_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      ptr_ff      <= ptr_in;
      page_ff     <= page_in;
      rmw_page_ff <= rmw_page_in;
      pin_val_ff  <= pin_val_in;
      try_clr_ff  <= try_clr_in;
      pend_new_ff <= pend_new_in;
      keep_ff     <= keep_in;
      slot_ff     <= slot_in;
      start_ff    <= start_in;
      nm1_ff      <= nm1_in;
      iss_w_ff    <= iss_w_in;
      iss_seg_ff  <= iss_seg_in;
      ev_w_ff     <= ev_w_in;
      ev_seg_ff   <= ev_seg_in;
      ev_last_ff  <= ev_last_in;
   end

   // bitmap and ring memories, one write and one registered read each
   always_ff @(posedge clock) begin
      if (pin_we) pin_mem[map_wa] <= pin_wd;
      if (try_we) try_mem[map_wa] <= try_wd;
      if (ring_we) ring_mem[ring_wa] <= ring_wd;
      pin_rd_ff  <= pin_mem[map_ra];
      try_rd_ff  <= try_mem[map_ra];
      ring_rd_ff <= ring_mem[ring_ra];
   end

endmodule

### rtl/pevp_rsp_q.sv
// ----------------------------------------------------------------------------
// pevp_rsp_q
// result queue between the engine and the result port
// ----------------------------------------------------------------------------
module pevp_rsp_q (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_push,
   input  pevp_pkg::rsp_type  rsp_data,
   output logic               rsp_full,
   output logic               empty,
   input  logic               pop,
   output logic [15:0]        rsp_victim_page,
   output logic               rsp_found,
   output logic               rsp_must_wait,
   output logic               rsp_tried_cleared
);
   import pevp_pkg::*;

   rsp_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;
   rsp_type     head;

   assign rsp_full = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = rsp_push && !rsp_full;
   assign do_pop   = pop && !empty;
   assign head     = q_ff[rd_ptr_ff];

   assign rsp_victim_page   = head.victim_page;
   assign rsp_found         = head.found;
   assign rsp_must_wait     = head.must_wait;
   assign rsp_tried_cleared = head.tried_cleared;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= rsp_data;
      end
   end

endmodule

### rtl/page_eviction_victim_picker_unit.sv
// ----------------------------------------------------------------------------
// page_eviction_victim_picker_unit
// clock-scan eviction victim picker with pinning of recently paged-in pages
// ----------------------------------------------------------------------------
// usage
//  - commands enter on a queue port: push/full with req_command and
//    req_page_number; a transfer happens when push is high and full is low
//  - every command gives exactly one result on the result queue port:
//    empty/pop, oldest result on the rsp_ ports while empty is low
//  - registers page_count, ring_depth_log2, retry_rounds are written through
//    csr_valid/csr_ready (ready always high), csr_index, csr_wdata; the user
//    must write only while the block has no command in flight (not enforced)
//  - choose scans one bitmap word per cycle (64 pages a word); one bitmap
//    read port sets that rate
//  - init and reset run a clearing pass over the bitmaps and the ring, one
//    word and one slot a cycle; after too many failed passes only the tried
//    map is cleared
//  - a two-entry command queue and a two-entry result queue part the sides:
//    when the receiver stalls, the engine finishes its current command and
//    waits, and full rises once the command queue fills
// ----------------------------------------------------------------------------
module page_eviction_victim_picker_unit #(
   parameter int PAGE_CAPACITY = pevp_pkg::PAGE_CAPACITY_DEF,
   parameter int RING_CAPACITY = pevp_pkg::RING_CAPACITY_DEF,
   parameter int WORD_BITS     = pevp_pkg::WORD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // command queue port
   input  logic         push,
   output logic         full,
   input  logic [2:0]   req_command,
   input  logic [15:0]  req_page_number,
   // result queue port
   output logic         empty,
   input  logic         pop,
   output logic [15:0]  rsp_victim_page,
   output logic         rsp_found,
   output logic         rsp_must_wait,
   output logic         rsp_tried_cleared,
   // register write port
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [16:0]  csr_wdata
);
   import pevp_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     cmd_valid, cmd_pop;
   cmd_type  cmd;
   logic     rsp_full, rsp_push;
   rsp_type  rsp_data;

   // register file, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PAGE_COUNT: cfg_in.page_count      = csr_wdata;
            CSR_RING_LOG2:  cfg_in.ring_depth_log2 = csr_wdata[RLOG_W-1:0];
            CSR_RETRY:      cfg_in.retry_rounds    = csr_wdata[RETRY_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_count      <= PAGE_COUNT_RESET;
         cfg_ff.ring_depth_log2 <= RING_LOG2_RESET;
         cfg_ff.retry_rounds    <= RETRY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: takes and classifies commands
   pevp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_command     (req_command),
      .req_page_number (req_page_number),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   // back: bitmaps, ring and scan
   pevp_engine #(
      .PAGE_CAPACITY (PAGE_CAPACITY),
      .RING_CAPACITY (RING_CAPACITY),
      .WORD_BITS     (WORD_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   // result queue
   pevp_rsp_q u_rsp_q (
      .clock             (clock),
      .reset             (reset),
      .rsp_push          (rsp_push),
      .rsp_data          (rsp_data),
      .rsp_full          (rsp_full),
      .empty             (empty),
      .pop               (pop),
      .rsp_victim_page   (rsp_victim_page),
      .rsp_found         (rsp_found),
      .rsp_must_wait     (rsp_must_wait),
      .rsp_tried_cleared (rsp_tried_cleared)
   );

   // engine never finishes a command into a full result queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   // engine starts a command only with room for its result
   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (cmd_valid && !rsp_full))
      else $error("command taken without result room");

   // found and must_wait exclude each other
   a_found_excl: assert property (@(posedge clock) disable iff (reset)
      !empty |-> !(rsp_found && rsp_must_wait))
      else $error("result both found and waiting");

   // clearing the tried map only follows a failed pass
   a_clear_needs_wait: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_tried_cleared) |-> (rsp_must_wait && !rsp_found))
      else $error("tried cleared without failed pass");

endmodule
